// ===== hw/rtl/rms_soft_knee_compressor_assert.svh =====
// Assertion macros for the RMS soft-knee compressor.
`ifndef RMS_SOFT_KNEE_COMPRESSOR_ASSERT_SVH
`define RMS_SOFT_KNEE_COMPRESSOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RSKC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rskc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RSKC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rskc assertion failed");

`endif

// ===== hw/rtl/rskc_pkg.sv =====
// Constants, register indexes and tables for the RMS soft-knee compressor.
package rskc_pkg;

    localparam int MS_FRAC    = 46;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [24:0] COEF_ONE         = 25'h100_0000;
    localparam logic [15:0] LEVEL_FLOOR_MAG  = 16'd30720;
    localparam logic [31:0] TEN_LOG10_2_Q24  = 32'd50504453;
    localparam logic [31:0] LOG2_10_20_Q24   = 32'd2786635;
    localparam logic [40:0] EXP_BIAS_Q16     = 41'd4194304;   // 64 in Q16
    localparam logic [7:0]  SHIFT_BASE       = 8'd94;         // 30 + 64

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD,
        REG_SLOPE,
        REG_KNEE,
        REG_MAKEUP,
        REG_RMS,
        REG_ATTACK,
        REG_RELEASE
    } cfg_reg_t;

    // 2^(2^-(i+1)) in Q1.30
    function automatic logic [31:0] pow2_frac_q30(input logic [3:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                4'd0:    v = 32'd1518500250;
                4'd1:    v = 32'd1276901417;
                4'd2:    v = 32'd1170923762;
                4'd3:    v = 32'd1121280440;
                4'd4:    v = 32'd1097253710;
                4'd5:    v = 32'd1085434107;
                4'd6:    v = 32'd1079572136;
                4'd7:    v = 32'd1076653033;
                4'd8:    v = 32'd1075196444;
                4'd9:    v = 32'd1074468888;
                4'd10:   v = 32'd1074105295;
                4'd11:   v = 32'd1073923544;
                4'd12:   v = 32'd1073832680;
                4'd13:   v = 32'd1073787251;
                4'd14:   v = 32'd1073764537;
                4'd15:   v = 32'd1073753181;
                default: v = 32'd1073741824;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== hw/rtl/rms_soft_knee_compressor.sv =====
// Stereo RMS soft-knee compressor: linked detector, gain computer, ballistics, gain stage.
//
// One stereo frame in, one frame out. The block is a sequencer around a single
// registered 32x32 multiplier plus a bit-serial divider. A frame is worked through
// in full before the next request is taken. Every frame passes the squares, the
// mean-square and ballistics updates, the gain computer compare, 16 mantissa steps
// for the exponent on the shared multiplier, both output products, and the idle
// state, which hands the result to the output register and then takes the next
// request. A nonzero mean square adds a normalize search for the log (one shift
// per clock), 16 squarings for the log fraction on the shared multiplier and the
// level scaling. The gain computer adds a slope product above the knee, or, inside
// the soft knee, a setup with two products followed by a 44-step restoring divide.
// in_stall is high from the accepted request until the result has been moved
// into the output register; that register holds the result until taken, so a
// new request is accepted while a finished one still waits on out_stall.
// Detector state (mean square, gain reduction) resets to zero. Configuration
// writes are always ready and must only be issued while the block is idle;
// coefficients above 1.0 are clipped to 1.0 on write, index 7 is ignored.
module rms_soft_knee_compressor #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       left_in,
    input  logic signed [SAMPLE_BITS-1:0]       right_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       left_out,
    output logic signed [SAMPLE_BITS-1:0]       right_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rskc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rskc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rskc_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int SQFRAC = 2 * (SB - 1);
    localparam int SQ_SHR = (SQFRAC >= MS_FRAC) ? (SQFRAC - MS_FRAC) : 0;
    localparam int SQ_SHL = (SQFRAC <  MS_FRAC) ? (MS_FRAC - SQFRAC) : 0;
    localparam logic [47:0] MS_ONE   = 48'h4000_0000_0000;
    localparam logic [21:0] LOG_TOP  = 22'd3014656;          // 46 in Q16
    localparam logic [64:0] MAXPOS   = (65'd1 << (SB - 1)) - 65'd1;

    typedef enum logic [5:0] {
        S_IDLE, S_SQL, S_SQR, S_SQSUM,
        S_MSHI, S_MSLO, S_MSUPD,
        S_LOGINIT, S_NORM, S_LOGSQ, S_LOGSQW, S_LVLMUL, S_LVL,
        S_GC, S_GC2, S_HARD0, S_HARD, S_KNEE0, S_KNEE1, S_KNEE2, S_DIV,
        S_BAL0, S_GRHI, S_GRLO, S_GRUPD,
        S_NET, S_EXPM, S_EXP, S_MANT, S_MANTW,
        S_APPL_L, S_APPL_R, S_APPL_W
    } state_t;

    // DONE is folded into S_APPL_W's successor; keep a separate hold state
    state_t state_reg;
    logic   hold_reg;      // result computed, waiting for the output register

    // configuration
    logic signed [15:0] thr_reg;
    logic [15:0]        slope_reg;
    logic [12:0]        knee_reg;
    logic signed [14:0] makeup_reg;
    logic [24:0]        rms_coef_reg;
    logic [24:0]        att_coef_reg;
    logic [24:0]        rel_coef_reg;

    // detector state
    logic [47:0] ms_reg;
    logic [31:0] gr_reg;

    // datapath
    logic signed [SB-1:0] l_reg, r_reg;
    logic [63:0]  prod_reg;
    logic [63:0]  sum_reg;
    logic [47:0]  d_reg;
    logic [47:0]  t_reg;
    logic [24:0]  coef_reg;
    logic         up_reg;
    logic [47:0]  nrm_reg;
    logic [5:0]   p_reg;
    logic [30:0]  x_reg;
    logic [15:0]  frac_reg;
    logic [3:0]   cnt_reg;
    logic signed [15:0] lvl_reg;
    logic signed [17:0] over_reg;
    logic [13:0]  x2_reg;
    logic [43:0]  num_reg;
    logic [24:0]  rem_reg;
    logic [5:0]   div_cnt_reg;
    logic [31:0]  tgt_reg;
    logic         neg_reg;
    logic [33:0]  nmag_reg;
    logic [15:0]  f_reg;
    logic signed [7:0] sh_reg;
    logic [30:0]  mant_reg;
    logic [SB-1:0] res_l_reg, res_r_reg;
    logic [SB-1:0] out_l_reg, out_r_reg;
    logic          out_valid_reg;

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;

    // combinational helpers
    logic [SB-1:0] l_mag, r_mag;
    logic [64:0]   sq_sum;
    logic [63:0]   sq_al;
    logic [47:0]   sq_val;
    logic [47:0]   step;
    logic [31:0]   log_y;
    logic [31:0]   lvl_mag;
    logic signed [18:0] two_over, wv;
    logic [24:0]   div_den;
    logic [24:0]   rem_sh;
    logic          div_ge;
    logic [31:0]   gr_diff;
    logic signed [33:0] net;
    logic [63:0]   emag_sum;
    logic [40:0]   emag;
    logic [40:0]   eb;
    logic [63:0]   mant_rnd;
    logic          out_free;
    logic [24:0]   cfg_coef;

    function automatic logic [SB-1:0] gain_out(
        input logic [63:0]       p,
        input logic signed [7:0] sh,
        input logic              neg
    );
        logic [64:0] r;
        logic [5:0]  amt;
        logic [64:0] nr;
        begin
            amt = sh[5:0];
            if (sh > 8'sd63) begin
                r = 65'd0;
            end
            else if (sh <= 8'sd0) begin
                r = {1'b0, p};
            end
            else begin
                r = ({1'b0, p} + (65'd1 << (amt - 6'd1))) >> amt;
            end
            if (neg) begin
                if (r > MAXPOS + 65'd1) begin
                    r = MAXPOS + 65'd1;
                end
                nr = ~r + 65'd1;
                return nr[SB-1:0];
            end
            if (r > MAXPOS) begin
                r = MAXPOS;
            end
            return r[SB-1:0];
        end
    endfunction

    always_comb
    begin
        l_mag    = l_reg[SB-1] ? (~l_reg + 1'b1) : l_reg;
        r_mag    = r_reg[SB-1] ? (~r_reg + 1'b1) : r_reg;
        sq_sum   = {1'b0, sum_reg} + {1'b0, prod_reg};
        sq_al    = (sq_sum[64:1] >> SQ_SHR) << SQ_SHL;
        sq_val   = sq_al[47:0];
        step     = t_reg + {24'd0, prod_reg[47:24]};
        log_y    = prod_reg[61:30];
        lvl_mag  = prod_reg[63:32] + {31'd0, prod_reg[31]};
        two_over = {over_reg, 1'b0};
        wv       = {6'd0, knee_reg};
        div_den  = {1'b0, knee_reg, 11'd0};
        rem_sh   = {rem_reg[23:0], num_reg[43]};
        div_ge   = (rem_sh >= div_den);
        gr_diff  = (tgt_reg > gr_reg) ? (tgt_reg - gr_reg) : (gr_reg - tgt_reg);
        net      = {{11{makeup_reg[14]}}, makeup_reg, 8'd0} - {2'b00, gr_reg};
        emag_sum = prod_reg + 64'h80_0000;
        emag     = {1'b0, emag_sum[63:24]};
        if (neg_reg) begin
            eb = (emag >= EXP_BIAS_Q16) ? 41'd0 : (EXP_BIAS_Q16 - emag);
        end
        else begin
            eb = EXP_BIAS_Q16 + emag;
        end
        mant_rnd = prod_reg + 64'h2000_0000;
        out_free = !(out_valid_reg && out_stall);
        cfg_coef = (cfg_data[24:0] > COEF_ONE) ? COEF_ONE : cfg_data[24:0];
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_SQL:
            begin
                mul_a = 32'(l_mag);
                mul_b = 32'(l_mag);
            end
            S_SQR:
            begin
                mul_a = 32'(r_mag);
                mul_b = 32'(r_mag);
            end
            S_MSHI, S_GRHI:
            begin
                mul_a = {8'd0, d_reg[47:24]};
                mul_b = {7'd0, coef_reg};
            end
            S_MSLO, S_GRLO:
            begin
                mul_a = {8'd0, d_reg[23:0]};
                mul_b = {7'd0, coef_reg};
            end
            S_LOGSQ:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, x_reg};
            end
            S_LVLMUL:
            begin
                mul_a = {10'd0, LOG_TOP - {p_reg, frac_reg}};
                mul_b = TEN_LOG10_2_Q24;
            end
            S_HARD0:
            begin
                mul_a = {15'd0, over_reg[16:0]};
                mul_b = {16'd0, slope_reg};
            end
            S_KNEE0:
            begin
                mul_a = {18'd0, x2_reg};
                mul_b = {16'd0, slope_reg};
            end
            S_KNEE1:
            begin
                mul_a = {2'd0, prod_reg[29:0]};
                mul_b = {18'd0, x2_reg};
            end
            S_EXPM:
            begin
                mul_a = nmag_reg[31:0];
                mul_b = LOG2_10_20_Q24;
            end
            S_MANT:
            begin
                mul_a = {1'b0, mant_reg};
                mul_b = pow2_frac_q30(cnt_reg);
            end
            S_APPL_L:
            begin
                mul_a = 32'(l_mag);
                mul_b = {1'b0, mant_reg};
            end
            S_APPL_R:
            begin
                mul_a = 32'(r_mag);
                mul_b = {1'b0, mant_reg};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            hold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            thr_reg       <= -16'sd5120;
            slope_reg     <= 16'd43690;
            knee_reg      <= 13'd2560;
            makeup_reg    <= 15'sd0;
            rms_coef_reg  <= COEF_ONE;
            att_coef_reg  <= COEF_ONE;
            rel_coef_reg  <= COEF_ONE;
            ms_reg        <= 48'd0;
            gr_reg        <= 32'd0;
            l_reg         <= '0;
            r_reg         <= '0;
            sum_reg       <= 64'd0;
            d_reg         <= 48'd0;
            t_reg         <= 48'd0;
            coef_reg      <= 25'd0;
            up_reg        <= 1'b0;
            nrm_reg       <= 48'd0;
            p_reg         <= 6'd0;
            x_reg         <= 31'd0;
            frac_reg      <= 16'd0;
            cnt_reg       <= 4'd0;
            lvl_reg       <= 16'sd0;
            over_reg      <= 18'sd0;
            x2_reg        <= 14'd0;
            num_reg       <= 44'd0;
            rem_reg       <= 25'd0;
            div_cnt_reg   <= 6'd0;
            tgt_reg       <= 32'd0;
            neg_reg       <= 1'b0;
            nmag_reg      <= 34'd0;
            f_reg         <= 16'd0;
            sh_reg        <= 8'sd0;
            mant_reg      <= 31'd0;
            res_l_reg     <= '0;
            res_r_reg     <= '0;
            out_l_reg     <= '0;
            out_r_reg     <= '0;
        end
        else begin
            if (cfg_valid) begin
                case (cfg_reg_t'(cfg_index))
                    REG_THRESHOLD: thr_reg      <= $signed(cfg_data[15:0]);
                    REG_SLOPE:     slope_reg    <= cfg_data[15:0];
                    REG_KNEE:      knee_reg     <= cfg_data[12:0];
                    REG_MAKEUP:    makeup_reg   <= $signed(cfg_data[14:0]);
                    REG_RMS:       rms_coef_reg <= cfg_coef;
                    REG_ATTACK:    att_coef_reg <= cfg_coef;
                    REG_RELEASE:   rel_coef_reg <= cfg_coef;
                    default:       ;
                endcase
            end

            // a pending result reloads the register in the same cycle instead
            if (out_valid_reg && !out_stall && !(hold_reg && state_reg == S_IDLE)) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (hold_reg) begin
                        if (out_free) begin
                            out_l_reg     <= res_l_reg;
                            out_r_reg     <= res_r_reg;
                            out_valid_reg <= 1'b1;
                            hold_reg      <= 1'b0;
                        end
                    end
                    else if (in_valid) begin
                        l_reg     <= left_in;
                        r_reg     <= right_in;
                        state_reg <= S_SQL;
                    end
                end
                S_SQL:   state_reg <= S_SQR;
                S_SQR:
                begin
                    sum_reg   <= prod_reg;
                    state_reg <= S_SQSUM;
                end
                S_SQSUM:
                begin
                    up_reg    <= (sq_val >= ms_reg);
                    d_reg     <= (sq_val >= ms_reg) ? (sq_val - ms_reg) : (ms_reg - sq_val);
                    coef_reg  <= rms_coef_reg;
                    state_reg <= S_MSHI;
                end
                S_MSHI:  state_reg <= S_MSLO;
                S_MSLO:
                begin
                    t_reg     <= prod_reg[47:0];
                    state_reg <= S_MSUPD;
                end
                S_MSUPD:
                begin
                    ms_reg    <= up_reg ? (ms_reg + step) : (ms_reg - step);
                    state_reg <= S_LOGINIT;
                end
                S_LOGINIT:
                begin
                    if (ms_reg == 48'd0) begin
                        lvl_reg   <= -$signed(LEVEL_FLOOR_MAG);
                        state_reg <= S_GC;
                    end
                    else begin
                        nrm_reg   <= (ms_reg > MS_ONE) ? MS_ONE : ms_reg;
                        p_reg     <= 6'd47;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (nrm_reg[47]) begin
                        x_reg     <= nrm_reg[47:17];
                        frac_reg  <= 16'd0;
                        cnt_reg   <= 4'd15;
                        state_reg <= S_LOGSQ;
                    end
                    else begin
                        nrm_reg <= {nrm_reg[46:0], 1'b0};
                        p_reg   <= p_reg - 6'd1;
                    end
                end
                S_LOGSQ: state_reg <= S_LOGSQW;
                S_LOGSQW:
                begin
                    if (log_y[31]) begin
                        x_reg             <= log_y[31:1];
                        frac_reg[cnt_reg] <= 1'b1;
                    end
                    else begin
                        x_reg <= log_y[30:0];
                    end
                    cnt_reg   <= cnt_reg - 4'd1;
                    state_reg <= (cnt_reg == 4'd0) ? S_LVLMUL : S_LOGSQ;
                end
                S_LVLMUL: state_reg <= S_LVL;
                S_LVL:
                begin
                    if (lvl_mag > {16'd0, LEVEL_FLOOR_MAG}) begin
                        lvl_reg <= -$signed(LEVEL_FLOOR_MAG);
                    end
                    else begin
                        lvl_reg <= -$signed(lvl_mag[15:0]);
                    end
                    state_reg <= S_GC;
                end
                S_GC:
                begin
                    over_reg  <= {{2{lvl_reg[15]}}, lvl_reg} - {{2{thr_reg[15]}}, thr_reg};
                    state_reg <= S_GC2;
                end
                S_GC2:
                begin
                    if (two_over <= -wv) begin
                        tgt_reg   <= 32'd0;
                        state_reg <= S_BAL0;
                    end
                    else if (two_over >= wv) begin
                        state_reg <= S_HARD0;
                    end
                    else begin
                        x2_reg    <= 14'(two_over + wv);
                        state_reg <= S_KNEE0;
                    end
                end
                S_HARD0: state_reg <= S_HARD;
                S_HARD:
                begin
                    tgt_reg   <= prod_reg[39:8];
                    state_reg <= S_BAL0;
                end
                S_KNEE0: state_reg <= S_KNEE1;
                S_KNEE1: state_reg <= S_KNEE2;
                S_KNEE2:
                begin
                    num_reg     <= prod_reg[43:0];
                    rem_reg     <= 25'd0;
                    div_cnt_reg <= 6'd43;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg     <= div_ge ? (rem_sh - div_den) : rem_sh;
                    num_reg     <= {num_reg[42:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == 6'd0) begin
                        tgt_reg   <= {num_reg[30:0], div_ge};
                        state_reg <= S_BAL0;
                    end
                end
                S_BAL0:
                begin
                    up_reg    <= (tgt_reg > gr_reg);
                    d_reg     <= {16'd0, gr_diff};
                    coef_reg  <= (tgt_reg > gr_reg) ? att_coef_reg : rel_coef_reg;
                    state_reg <= S_GRHI;
                end
                S_GRHI:  state_reg <= S_GRLO;
                S_GRLO:
                begin
                    t_reg     <= prod_reg[47:0];
                    state_reg <= S_GRUPD;
                end
                S_GRUPD:
                begin
                    gr_reg    <= up_reg ? (gr_reg + step[31:0]) : (gr_reg - step[31:0]);
                    state_reg <= S_NET;
                end
                S_NET:
                begin
                    neg_reg   <= net[33];
                    nmag_reg  <= net[33] ? 34'(-net) : 34'(net);
                    state_reg <= S_EXPM;
                end
                S_EXPM:  state_reg <= S_EXP;
                S_EXP:
                begin
                    f_reg     <= eb[15:0];
                    sh_reg    <= $signed(SHIFT_BASE - {1'b0, eb[22:16]});
                    mant_reg  <= 31'h4000_0000;
                    cnt_reg   <= 4'd0;
                    state_reg <= S_MANT;
                end
                S_MANT:  state_reg <= S_MANTW;
                S_MANTW:
                begin
                    if (f_reg[4'd15 - cnt_reg]) begin
                        mant_reg <= mant_rnd[60:30];
                    end
                    cnt_reg   <= cnt_reg + 4'd1;
                    state_reg <= (cnt_reg == 4'd15) ? S_APPL_L : S_MANT;
                end
                S_APPL_L: state_reg <= S_APPL_R;
                S_APPL_R:
                begin
                    res_l_reg <= gain_out(prod_reg, sh_reg, l_reg[SB-1]);
                    state_reg <= S_APPL_W;
                end
                S_APPL_W:
                begin
                    res_r_reg <= gain_out(prod_reg, sh_reg, r_reg[SB-1]);
                    hold_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || hold_reg;
    assign out_valid = out_valid_reg;
    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;
    assign cfg_ready = 1'b1;

`include "rms_soft_knee_compressor_assert.svh"

    // an accepted request always makes the block busy
    `RSKC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // a pending result moves out as soon as the output register is free
    `RSKC_ASSERT_NEXT(a_hold_drains, hold_reg && state_reg == S_IDLE && out_free, out_valid && !hold_reg)
    // mean square never passes full scale squared
    `RSKC_ASSERT_SAME(a_ms_bound, 1'b1, ms_reg <= MS_ONE)
    // gain reduction stays inside the largest reachable target
    `RSKC_ASSERT_SAME(a_gr_bound, 1'b1, gr_reg < 32'h80_0000)
    // log squaring always starts from a normalized value
    `RSKC_ASSERT_SAME(a_log_norm, state_reg == S_LOGSQ, x_reg[30])

endmodule

// ===== bench/tb.sv =====
// Testbench for the stereo RMS soft-knee compressor: predicted frames checked per request.
`timescale 1ns / 100ps

module tb;
    import rskc_pkg::*;

    localparam int SB          = 24;
    localparam int WATCH_LIMIT = 20000;   // cycles with no handshake at all
    localparam int TAIL_CYCLES = 400;     // settling time after the last result
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off

    typedef struct packed {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
    } frame_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [SB-1:0] left_in;
    logic signed [SB-1:0] right_in;
    logic out_valid;
    logic out_stall;
    logic signed [SB-1:0] left_out;
    logic signed [SB-1:0] right_out;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rms_soft_knee_compressor #(.SAMPLE_BITS(SB)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .left_in(left_in), .right_in(right_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .left_out(left_out), .right_out(right_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor copy of the register file and detector state
    int              thr_q8;
    longint unsigned slope_q16;
    longint unsigned knee_q8;
    int              makeup_q8;
    longint unsigned rms_c;
    longint unsigned atk_c;
    longint unsigned rel_c;
    longint unsigned ms_q46;
    longint unsigned gr_q16;

    frame_t expected_frames[$];
    int     errors;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_requests;
    int     hold_served;
    int     hold_left;
    int     quiet_cycles;

    // 2^(2^-(i+1)) in Q1.30
    longint unsigned exp_steps[16] = '{
        64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280440,
        64'd1097253710, 64'd1085434107, 64'd1079572136, 64'd1076653033,
        64'd1075196444, 64'd1074468888, 64'd1074105295, 64'd1073923544,
        64'd1073832680, 64'd1073787251, 64'd1073764537, 64'd1073753181
    };

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint unsigned scale_q24(longint unsigned a, longint unsigned c);
        return (a >> 24) * c + (((a & 64'hFF_FFFF) * c) >> 24);
    endfunction

    function automatic longint unsigned clip_coef(logic [CFG_DATA_W-1:0] v);
        return (v > COEF_ONE) ? longint'(COEF_ONE) : longint'(v);
    endfunction

    // Mean square (Q0.46) to level in 1/256 dB, floored at -120 dB
    function automatic longint level_q8(longint unsigned ms);
        int              p;
        longint unsigned t;
        longint unsigned x;
        longint unsigned frac;
        longint unsigned neg;
        longint unsigned mag;
        p = 0;
        frac = 0;
        if (ms == 0)
            return -30720;
        if (ms > (64'd1 << MS_FRAC))
            ms = 64'd1 << MS_FRAC;
        for (t = ms; t > 1; t = t >> 1)
            p++;
        x = (p > 30) ? (ms >> (p - 30)) : (ms << (30 - p));
        for (int i = 15; i >= 0; i--)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31))
            begin
                x = x >> 1;
                frac = frac | (64'd1 << i);
            end
        end
        neg = (longint'(MS_FRAC) << 16) - ((longint'(p) << 16) | frac);
        mag = (neg * longint'(TEN_LOG10_2_Q24) + (64'd1 << 31)) >> 32;
        return (-longint'(mag) < -30720) ? -30720 : -longint'(mag);
    endfunction

    // Soft-knee gain computer, Q16 dB of reduction
    function automatic longint unsigned knee_target(longint lvl);
        longint over;
        longint w;
        longint unsigned x2;
        over = lvl - thr_q8;
        w = longint'(knee_q8);
        if (2 * over <= -w)
            return 0;
        if (2 * over >= w)
            return (slope_q16 * longint'(unsigned'(over))) >> 8;
        if (w == 0)
            return 0;
        x2 = longint'(unsigned'(2 * over + w));
        return (slope_q16 * x2 * x2) / (2048 * longint'(unsigned'(w)));
    endfunction

    function automatic logic [SB-1:0] scale_sample(longint s, longint unsigned mant, longint n);
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned r;
        longint unsigned maxpos;
        longint sh;
        maxpos = (64'd1 << (SB - 1)) - 1;
        mag = (s < 0) ? longint'(unsigned'(-s)) : longint'(unsigned'(s));
        prod = mag * mant;
        sh = 30 - n;
        if (sh > 63)
            r = 0;
        else if (sh <= 0)
            r = prod;
        else
            r = (prod + (64'd1 << (sh - 1))) >> sh;
        if (s < 0)
        begin
            if (r > maxpos + 1)
                r = maxpos + 1;
            return SB'(64'd0 - r);
        end
        if (r > maxpos)
            r = maxpos;
        return SB'(r);
    endfunction

    // Advances detector state by one frame and returns the processed frame
    function automatic frame_t compress_frame(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
        longint          ls;
        longint          rs;
        longint unsigned lm;
        longint unsigned rm;
        longint unsigned sq;
        longint unsigned tgt;
        longint unsigned g;
        longint unsigned emag;
        longint unsigned eb;
        longint unsigned mant;
        longint          net;
        longint          e;
        longint          n;
        frame_t          res;
        ls = l;
        rs = r;
        lm = (ls < 0) ? longint'(unsigned'(-ls)) : longint'(unsigned'(ls));
        rm = (rs < 0) ? longint'(unsigned'(-rs)) : longint'(unsigned'(rs));
        sq = (lm * lm + rm * rm) >> 1;
        if (2 * (SB - 1) >= MS_FRAC)
            sq = sq >> (2 * (SB - 1) - MS_FRAC);
        else
            sq = sq << (MS_FRAC - 2 * (SB - 1));
        if (sq >= ms_q46)
            ms_q46 = ms_q46 + scale_q24(sq - ms_q46, rms_c);
        else
            ms_q46 = ms_q46 - scale_q24(ms_q46 - sq, rms_c);

        tgt = knee_target(level_q8(ms_q46));
        g = gr_q16;
        if (tgt > g)
            g = g + scale_q24(tgt - g, atk_c);
        else
            g = g - scale_q24(g - tgt, rel_c);
        gr_q16 = g & 64'hFFFF_FFFF;

        // log2 of the linear gain in Q16, then 2^frac from the step table
        net = longint'(makeup_q8) * 256 - longint'(g);
        emag = ((net < 0 ? longint'(unsigned'(-net)) : longint'(unsigned'(net)))
                * longint'(LOG2_10_20_Q24) + (64'd1 << 23)) >> 24;
        e = (net < 0) ? -longint'(emag) : longint'(emag);
        if (e < -64 * 65536)
            e = -64 * 65536;
        eb = longint'(unsigned'(e + 64 * 65536));
        n = longint'(eb >> 16) - 64;
        mant = 64'd1 << 30;
        for (int i = 0; i < 16; i++)
        begin
            if (eb[15 - i])
                mant = (mant * exp_steps[i] + (64'd1 << 29)) >> 30;
        end
        res.left = scale_sample(ls, mant, n);
        res.right = scale_sample(rs, mant, n);
        return res;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_q8 = int'(signed'(val[15:0]));
            REG_SLOPE:     slope_q16 = val[15:0];
            REG_KNEE:      knee_q8 = val[12:0];
            REG_MAKEUP:    makeup_q8 = int'(signed'(val[14:0]));
            REG_RMS:       rms_c = clip_coef(val);
            REG_ATTACK:    atk_c = clip_coef(val);
            REG_RELEASE:   rel_c = clip_coef(val);
            default:       ;
        endcase
    endtask

    // Leaves valid high after acceptance so back-to-back requests need no re-raise
    task automatic send_frame(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        left_in <= l;
        right_in <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_frames.push_back(compress_frame(l, r));
    endtask

    // Drops valid, waits for every result, then for the block to settle
    task automatic drain;
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SB-1:0] pick_sample(int amp_shift);
        logic signed [SB-1:0] v;
        case ($urandom_range(9))
            0:       v = {1'b1, {(SB-1){1'b0}}};
            1:       v = {1'b0, {(SB-1){1'b1}}};
            2:       v = '0;
            3, 4:    v = SB'($urandom);
            default: v = SB'(signed'($urandom_range(32'h7F_FFFF)) >>> amp_shift);
        endcase
        if ($urandom_range(1))
            v = -v;
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef;
        case ($urandom_range(7))
            0:       return COEF_ONE;
            1:       return CFG_DATA_W'($urandom);   // may be above 1.0
            2:       return CFG_DATA_W'($urandom_range(16));
            default: return CFG_DATA_W'(32'd1 << $urandom_range(24, 12)) +
                            CFG_DATA_W'($urandom_range(4095));
        endcase
    endfunction

    task automatic randomize_regs;
        write_reg(REG_THRESHOLD, CFG_DATA_W'(-$urandom_range(24576)));
        write_reg(REG_SLOPE, CFG_DATA_W'($urandom_range(65535)));
        write_reg(REG_KNEE, ($urandom_range(3) == 0) ? '0 : CFG_DATA_W'($urandom_range(6144)));
        write_reg(REG_MAKEUP, CFG_DATA_W'($urandom_range(18432)) - CFG_DATA_W'(6144));
        write_reg(REG_RMS, pick_coef());
        write_reg(REG_ATTACK, pick_coef());
        write_reg(REG_RELEASE, pick_coef());
    endtask

    // Reset defaults: silence, full scale both polarities, then release back to quiet
    task automatic test_reset_defaults;
        send_frame('0, '0);
        send_frame({1'b0, {(SB-1){1'b1}}}, {1'b0, {(SB-1){1'b1}}});
        send_frame({1'b1, {(SB-1){1'b0}}}, {1'b1, {(SB-1){1'b0}}});
        send_frame({1'b1, {(SB-1){1'b0}}}, {1'b0, {(SB-1){1'b1}}});
        send_frame(24'sd1, -24'sd1);
        send_frame(24'sh55_5555, 24'shAA_AAAA);
        send_frame('0, '0);
        drain();
    endtask

    // Register extremes, hard knee, clipped coefficients, out-of-range values
    task automatic test_register_extremes;
        write_reg(REG_THRESHOLD, 25'd0);
        write_reg(REG_SLOPE, 25'd65535);
        write_reg(REG_KNEE, 25'd0);                 // hard knee
        write_reg(REG_MAKEUP, CFG_DATA_W'(12288));
        write_reg(REG_RMS, 25'h1FF_FFFF);          // clipped to instant
        write_reg(REG_ATTACK, 25'h1FF_FFFF);
        write_reg(REG_RELEASE, 25'd0);             // reduction never falls
        send_frame(24'sh40_0000, -24'sh40_0000);
        send_frame(24'sh7F_FFFF, 24'sh7F_FFFF);
        send_frame(24'sh00_0100, 24'sh00_0000);
        drain();
        write_reg(REG_THRESHOLD, CFG_DATA_W'(-24576));
        write_reg(REG_KNEE, 25'd6144);
        write_reg(REG_MAKEUP, CFG_DATA_W'(-6144));
        write_reg(REG_SLOPE, 25'd0);
        write_reg(REG_RELEASE, COEF_ONE);
        write_reg(REG_RMS, 25'd1);                 // nearly frozen detector
        send_frame(24'sh7F_FFFF, 24'sh80_0000);
        send_frame(24'sh12_3456, -24'sh00_0777);
        drain();
        // Raw values beyond the stated ranges go through as written
        write_reg(REG_THRESHOLD, CFG_DATA_W'(-32768));
        write_reg(REG_SLOPE, 25'd65535);
        write_reg(REG_KNEE, 25'h1FFF);
        write_reg(REG_MAKEUP, 25'h4000);            // most negative 15-bit value
        write_reg(REG_RMS, COEF_ONE);
        write_reg(REG_ATTACK, 25'd0);
        send_frame(24'sh7F_FFFF, 24'sh7F_FFFF);
        send_frame(24'sh00_0800, 24'sh00_0400);
        drain();
        write_reg(REG_ATTACK, COEF_ONE);
        write_reg(REG_THRESHOLD, 25'h7FFF);
        write_reg(REG_MAKEUP, 25'h3FFF);
        send_frame(24'sh00_1000, -24'sh00_1000);
        send_frame('0, '0);
        drain();
    endtask

    // Bursts of one loudness with random content, so the detector settles and moves
    task automatic test_random_program(int frames);
        int sent;
        int burst;
        int amp;
        sent = 0;
        randomize_regs();
        while (sent < frames)
        begin
            burst = $urandom_range(20, 4);
            amp = $urandom_range(20);
            for (int i = 0; i < burst && sent < frames; i++)
            begin
                send_frame(pick_sample(amp), pick_sample(amp));
                sent++;
            end
            if ($urandom_range(9) == 0)
            begin
                drain();
                randomize_regs();
            end
        end
        drain();
    endtask

    // Receiver holds off while requests keep coming, so the input side backs up
    task automatic test_output_hold_off;
        hold_requests++;
        for (int i = 0; i < 30; i++)
            send_frame(pick_sample(2), pick_sample(6));
        drain();
    endtask

    // Result checker, receiver stall, and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    $display("%0t: unexpected frame L=%0d R=%0d", $time, left_out, right_out);
                    errors++;
                end
                else
                begin
                    if (left_out !== expected_frames[0].left)
                    begin
                        $display("%0t: left_out expected %0d actual %0d",
                                 $time, expected_frames[0].left, left_out);
                        errors++;
                    end
                    if (right_out !== expected_frames[0].right)
                    begin
                        $display("%0t: right_out expected %0d actual %0d",
                                 $time, expected_frames[0].right, right_out);
                        errors++;
                    end
                    void'(expected_frames.pop_front());
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);

            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCH_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        in_valid <= 1'b0;
        left_in <= '0;
        right_in <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_THRESHOLD;
        cfg_data <= '0;
        rst_n <= 1'b0;
        errors = 0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        quiet_cycles = 0;
        send_idle_pct = 6;
        recv_idle_pct = 46;
        // Reset state of the predictor
        thr_q8 = -5120;
        slope_q16 = 43690;
        knee_q8 = 2560;
        makeup_q8 = 0;
        rms_c = COEF_ONE;
        atk_c = COEF_ONE;
        rel_c = COEF_ONE;
        ms_q46 = 0;
        gr_q16 = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_program(170);
        send_idle_pct = 46;
        recv_idle_pct = 6;
        test_random_program(170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_program(170);
        test_output_hold_off();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== rms_soft_knee_compressor.f =====
+incdir+hw/rtl
hw/rtl/rskc_pkg.sv
hw/rtl/rms_soft_knee_compressor.sv
bench/tb.sv
